>>> src/spbm_pkg.sv
// Shared constants, types and helpers of the sparse paged byte memory.
package spbm_pkg;

  localparam int PAGE_SLOTS = 64;
  localparam int PAGE_BYTES = 256;
  localparam int SLOT_W     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int OFF_W      = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = 32 - OFF_W;
  localparam int MEM_AW     = SLOT_W + OFF_W;
  localparam int CNT_W      = OFF_W + 1;
  localparam int USED_RAW_W = $clog2(PAGE_SLOTS + 1);
  localparam int USED_W     = (USED_RAW_W > 7) ? USED_RAW_W : 7;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // One classified transaction, write bytes already in address order.
  typedef struct packed {
    logic            cmd;
    logic [31:0]     addr;
    logic [1:0]      size_code;
    logic            sext;
    logic            msb_first;
    logic [7:0][7:0] bytes;
  } desc_t;

  // Index of the last byte of an access.
  function automatic logic [2:0] last_index(input logic [1:0] size_code);
    logic [2:0] r;
    unique case (size_code)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

>>> src/spbm_front.sv
// Front end: holds the byte order register and classifies incoming transactions.
module spbm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_command,
  input  logic [31:0]   in_address,
  input  logic [1:0]    in_size_code,
  input  logic          in_sign_extend,
  input  logic [63:0]   in_write_data,
  output logic          push,
  output spbm_pkg::desc_t push_desc,
  input  logic          fifo_full
);
  import spbm_pkg::*;

  logic       msb_first_r;
  logic       msb_first_nxt;
  logic [2:0] last;

  // Update byte order register
  always_comb begin
    msb_first_nxt = msb_first_r;
    if (cfg_we) begin
      msb_first_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msb_first_r <= 1'b0;
    end else begin
      msb_first_r <= msb_first_nxt;
    end
  end

  assign in_ready = !fifo_full;
  assign push     = in_valid && !fifo_full;
  assign last     = last_index(in_size_code);

  // Reorder write lanes into address order
  always_comb begin
    push_desc.cmd        = in_command;
    push_desc.addr       = in_address;
    push_desc.size_code  = in_size_code;
    push_desc.sext       = in_sign_extend;
    push_desc.msb_first  = msb_first_r;
    for (int i = 0; i < 8; i++) begin
      if (msb_first_r) begin
        push_desc.bytes[i] = in_write_data[8*(3'(last - 3'(i))) +: 8];
      end else begin
        push_desc.bytes[i] = in_write_data[8*i +: 8];
      end
    end
  end

endmodule

>>> src/spbm_fifo.sv
// Short transaction queue between the front end and the back end.
module spbm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  spbm_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output spbm_pkg::desc_t head
);
  import spbm_pkg::*;

  desc_t                 store_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = store_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> src/spbm_back.sv
// Back end: per-byte page lookup, slot allocation, byte store and result register.
module spbm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  spbm_pkg::desc_t     q_desc,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_read_data,
  output logic                out_no_free_page,
  output logic [6:0]          out_resident_pages
);
  import spbm_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Slot table
  logic [PAGE_W-1:0]     tag_r    [PAGE_SLOTS];
  logic [PAGE_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;

  // Memories
  logic [7:0]       byte_mem [PAGE_SLOTS*PAGE_BYTES];
  logic [CNT_W-1:0] cnt_mem  [PAGE_SLOTS];
  logic [7:0]       byte_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;

  logic [MEM_AW-1:0] clr_r, clr_nxt;
  desc_t             cur_r, cur_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              flag_r, flag_nxt;
  logic [7:0][7:0]   rbuf_r, rbuf_nxt;

  // Lookup results
  logic [31:0]       addr_i;
  logic              hit_c, free_c;
  logic [SLOT_W-1:0] hit_slot_c, free_slot_c;
  logic              hit_r, free_r;
  logic [SLOT_W-1:0] hit_slot_r, free_slot_r;
  logic [PAGE_W-1:0] page_r;
  logic [OFF_W-1:0]  off_r;

  // Write ports
  logic              bw_en, cw_en, tag_we;
  logic [MEM_AW-1:0] bw_addr;
  logic [7:0]        bw_data;
  logic [SLOT_W-1:0] cw_addr;
  logic [CNT_W-1:0]  cw_data;
  logic [CNT_W-1:0]  new_cnt;
  logic [7:0]        wval;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic              out_flag_r, out_flag_nxt;
  logic [6:0]        out_pages_r, out_pages_nxt;
  logic [63:0]       load_val;
  logic [2:0]        last;

  assign addr_i = cur_r.addr + 32'(idx_r);
  assign last   = last_index(cur_r.size_code);
  assign wval   = cur_r.bytes[idx_r];

  // Search slot table for the page and for the lowest free slot
  always_comb begin
    hit_c       = 1'b0;
    hit_slot_c  = '0;
    free_c      = 1'b0;
    free_slot_c = '0;
    for (int s = 0; s < PAGE_SLOTS; s++) begin
      if (in_use_r[s] && tag_r[s] == addr_i[31:OFF_W]) begin
        hit_c      = 1'b1;
        hit_slot_c = hit_slot_c | SLOT_W'(s);
      end
    end
    for (int s = PAGE_SLOTS - 1; s >= 0; s--) begin
      if (!in_use_r[s]) begin
        free_c      = 1'b1;
        free_slot_c = SLOT_W'(s);
      end
    end
  end

  // Assemble loaded value: byte order, then sign extension
  always_comb begin
    load_val = '0;
    for (int j = 0; j < 8; j++) begin
      if (3'(j) <= last) begin
        if (cur_r.msb_first) begin
          load_val[8*j +: 8] = rbuf_r[3'(last - 3'(j))];
        end else begin
          load_val[8*j +: 8] = rbuf_r[j];
        end
      end
    end
    if (cur_r.sext) begin
      unique case (cur_r.size_code)
        2'd0:    load_val[63:8]  = {56{load_val[7]}};
        2'd1:    load_val[63:16] = {48{load_val[15]}};
        2'd2:    load_val[63:32] = {32{load_val[31]}};
        default: load_val = load_val;
      endcase
    end
  end

  // Sequence the per-byte steps
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    flag_nxt      = flag_r;
    rbuf_nxt      = rbuf_r;
    in_use_nxt    = in_use_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_flag_nxt  = out_flag_r;
    out_pages_nxt = out_pages_r;
    q_pop         = 1'b0;
    bw_en         = 1'b0;
    bw_addr       = {hit_slot_r, off_r};
    bw_data       = wval;
    cw_en         = 1'b0;
    cw_addr       = hit_slot_r;
    cw_data       = '0;
    tag_we        = 1'b0;
    new_cnt       = cnt_rd_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        bw_en   = 1'b1;
        bw_addr = clr_r;
        bw_data = '0;
        cw_en   = 1'b1;
        cw_addr = clr_r[MEM_AW-1:OFF_W];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_desc;
          idx_nxt   = '0;
          flag_nxt  = 1'b0;
          rbuf_nxt  = '0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (cur_r.cmd == CMD_READ) begin
          rbuf_nxt[idx_r] = hit_r ? byte_rd_r : 8'h00;
        end else if (hit_r) begin
          // Rewrite byte, track nonzero count, release an emptied slot
          bw_en = 1'b1;
          if (byte_rd_r != 8'h00 && wval == 8'h00) begin
            new_cnt = cnt_rd_r - 1'b1;
          end else if (byte_rd_r == 8'h00 && wval != 8'h00) begin
            new_cnt = cnt_rd_r + 1'b1;
          end
          cw_en   = 1'b1;
          cw_data = new_cnt;
          if (new_cnt == '0) begin
            in_use_nxt[hit_slot_r] = 1'b0;
            used_nxt               = used_r - 1'b1;
          end
        end else if (wval != 8'h00) begin
          if (free_r) begin
            // Claim the lowest free slot; its bytes are already zero
            bw_en                   = 1'b1;
            bw_addr                 = {free_slot_r, off_r};
            cw_en                   = 1'b1;
            cw_addr                 = free_slot_r;
            cw_data                 = CNT_W'(1);
            tag_we                  = 1'b1;
            in_use_nxt[free_slot_r] = 1'b1;
            used_nxt                = used_r + 1'b1;
          end else begin
            flag_nxt = 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOOK;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (cur_r.cmd == CMD_READ) ? load_val : 64'h0;
          out_flag_nxt  = flag_r;
          out_pages_nxt = used_r[6:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      in_use_r    <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      in_use_r    <= in_use_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload registers and lookup results
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    flag_r      <= flag_nxt;
    rbuf_r      <= rbuf_nxt;
    out_data_r  <= out_data_nxt;
    out_flag_r  <= out_flag_nxt;
    out_pages_r <= out_pages_nxt;
    if (state_r == ST_LOOK) begin
      hit_r       <= hit_c;
      hit_slot_r  <= hit_slot_c;
      free_r      <= free_c;
      free_slot_r <= free_slot_c;
      page_r      <= addr_i[31:OFF_W];
      off_r       <= addr_i[OFF_W-1:0];
    end
    if (tag_we) begin
      tag_r[free_slot_r] <= page_r;
    end
  end

  // Byte store and count store: one write, one registered read
  always_ff @(posedge clk) begin
    if (bw_en) begin
      byte_mem[bw_addr] <= bw_data;
    end
    byte_rd_r <= byte_mem[{hit_slot_c, addr_i[OFF_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cnt_mem[cw_addr] <= cw_data;
    end
    cnt_rd_r <= cnt_mem[hit_slot_c];
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;
  assign out_no_free_page   = out_flag_r;
  assign out_resident_pages = out_pages_r;

endmodule

>>> src/sparse_paged_byte_memory.sv
// Each transaction is handled byte by byte: a lookup step, then a read-modify-write step
// for each byte, before the result is offered. The back end takes one transaction at a time;
// a two-entry queue decouples input and holds further transactions while it is busy.
// Reset (synchronous, rst_n low) clears control state and byte order, then a clearing
// pass zeroes the byte store before the first transaction is taken.
module sparse_paged_byte_memory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_address,
  input  logic [1:0]  in_size_code,
  input  logic        in_sign_extend,
  input  logic [63:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_read_data,
  output logic        out_no_free_page,
  output logic [6:0]  out_resident_pages
);
  import spbm_pkg::*;

  logic  push, full, pop, not_empty;
  desc_t push_desc, head;

  spbm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_address     (in_address),
    .in_size_code   (in_size_code),
    .in_sign_extend (in_sign_extend),
    .in_write_data  (in_write_data),
    .push           (push),
    .push_desc      (push_desc),
    .fifo_full      (full)
  );

  spbm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  spbm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (not_empty),
    .q_desc             (head),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_no_free_page   (out_no_free_page),
    .out_resident_pages (out_resident_pages)
  );

endmodule

>>> tb/tb_sparse_paged_byte_memory.sv
// Self-checking testbench for the sparse paged byte memory: random and directed accesses.
`timescale 1ns / 100ps

// Tracks the memory image and compares each result against the predicted one.
class spbm_scoreboard;
  bit [7:0]  byte_store [bit [31:0]];     // nonzero bytes only
  int        page_nonzero [bit [23:0]];   // nonzero count per resident page
  int        page_slot [bit [23:0]];      // slot index held by each resident page
  bit        slot_busy [spbm_pkg::PAGE_SLOTS];
  bit        msb_first;
  bit [63:0] exp_data [$];
  bit        exp_full [$];
  bit [6:0]  exp_pages [$];
  int        mismatches;
  int        checked;
  int        full_hits;

  function automatic bit [7:0] peek(bit [31:0] a);
    return byte_store.exists(a) ? byte_store[a] : 8'h00;
  endfunction

  // Write one byte; return 1 when the pool has no free slot.
  function automatic bit poke(bit [31:0] a, bit [7:0] v);
    bit [23:0] pg;
    bit [7:0]  old;
    int        f;
    pg = a[31:8];
    if (!page_nonzero.exists(pg)) begin
      if (v == 0) return 0;
      f = -1;
      for (int s = 0; s < spbm_pkg::PAGE_SLOTS; s++)
        if (!slot_busy[s] && f < 0) f = s;
      if (f < 0) return 1;
      slot_busy[f] = 1;
      page_slot[pg] = f;
      page_nonzero[pg] = 1;
      byte_store[a] = v;
      return 0;
    end
    old = peek(a);
    if (v == 0) byte_store.delete(a); else byte_store[a] = v;
    if (old != 0 && v == 0) page_nonzero[pg]--;
    else if (old == 0 && v != 0) page_nonzero[pg]++;
    if (page_nonzero[pg] == 0) begin
      slot_busy[page_slot[pg]] = 0;
      page_slot.delete(pg);
      page_nonzero.delete(pg);
    end
    return 0;
  endfunction

  // Predict the result of one accepted transaction.
  function void note_access(bit cmd, bit [31:0] addr, bit [1:0] sz, bit sext,
                            bit [63:0] wdata);
    int        n;
    int        lane;
    bit [63:0] rd;
    bit        full;
    n = 1 << sz;
    rd = 0;
    full = 0;
    for (int i = 0; i < n; i++) begin
      lane = msb_first ? (n - 1 - i) : i;
      if (cmd == spbm_pkg::CMD_WRITE) begin
        if (poke(addr + i, wdata[lane*8 +: 8])) full = 1;
      end else begin
        rd[lane*8 +: 8] = peek(addr + i);
      end
    end
    if (cmd == spbm_pkg::CMD_READ && sext && n < 8 && rd[n*8-1])
      rd = rd | ~((64'd1 << (n*8)) - 64'd1);
    exp_data  = {exp_data, rd};
    exp_full  = {exp_full, full};
    exp_pages = {exp_pages, 7'(page_nonzero.num())};
  endfunction

  // Compare one accepted result with the oldest prediction.
  function void check_result(bit [63:0] rd, bit full, bit [6:0] pages);
    bit [63:0] e_rd;
    bit        e_full;
    bit [6:0]  e_pg;
    if (exp_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result rd=%h", rd);
      return;
    end
    e_rd = exp_data.pop_front();
    e_full = exp_full.pop_front();
    e_pg = exp_pages.pop_front();
    checked++;
    if (e_full) full_hits++;
    if (rd !== e_rd || full !== e_full || pages !== e_pg) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: exp rd=%h nfp=%b pages=%0d got rd=%h nfp=%b pages=%0d",
                 checked, e_rd, e_full, e_pg, rd, full, pages);
    end
  endfunction
endclass

module tb_sparse_paged_byte_memory;
  import spbm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [31:0] in_address;
  logic [1:0]  in_size_code;
  logic        in_sign_extend;
  logic [63:0] in_write_data;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_read_data;
  logic        out_no_free_page;
  logic [6:0]  out_resident_pages;

  spbm_scoreboard board;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  int  leftover;

  // Page bases used for random traffic: a small set so pages fill and drain.
  bit [31:0] page_pool [80];

  sparse_paged_byte_memory dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_address(in_address), .in_size_code(in_size_code),
    .in_sign_extend(in_sign_extend), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .out_no_free_page(out_no_free_page), .out_resident_pages(out_resident_pages)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Watchdog: clearing pass plus ~1000 slow transactions, several times over.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Note accepted input and check accepted results at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_access(in_command, in_address, in_size_code, in_sign_extend,
                        in_write_data);
    if (rst_n && out_valid && out_ready)
      board.check_result(out_read_data, out_no_free_page, out_resident_pages);
  end

  // Drive ready at the falling edge; a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one transaction, with random idle gaps before it; valid stays up after
  // acceptance until the next falling edge drives the next transaction or idles.
  task automatic send_access(bit cmd, bit [31:0] addr, bit [1:0] sz, bit sext,
                             bit [63:0] wdata);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_address     <= addr;
    in_size_code   <= sz;
    in_sign_extend <= sext;
    in_write_data  <= wdata;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, then wait until every predicted result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.exp_data.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic set_order(bit be);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= be;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.msb_first = be;
  endtask

  // Random transaction: mostly writes and reads within the page pool.
  task automatic random_access();
    bit [31:0] base;
    bit [63:0] wd;
    bit [1:0]  sz;
    base = page_pool[$urandom_range(79)];
    sz = 2'($urandom_range(3));
    wd = {$urandom, $urandom};
    case ($urandom_range(5))
      0: wd = 64'd0;                          // clears bytes, frees slots
      1: wd = wd & {4{8'h00, 8'hFF}};
      default: ;
    endcase
    if ($urandom_range(9) == 0) base = {$urandom};
    send_access(1'($urandom_range(1)), base + $urandom_range(255), sz,
                1'($urandom_range(1)), wd);
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_READ;
    in_address = '0;
    in_size_code = '0;
    in_sign_extend = 1'b0;
    in_write_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    for (int i = 0; i < 80; i++) page_pool[i] = {$urandom} & 32'hFFFF_FF00;
    page_pool[0] = 32'hFFFF_FF00;
    page_pool[1] = 32'h0000_0000;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, wrap, sign extension, both byte orders.
    send_access(CMD_READ,  32'h0000_0000, 2'd3, 1'b1, 64'd0);
    send_access(CMD_WRITE, 32'hFFFF_FFFC, 2'd3, 1'b1, 64'hFEDC_BA98_7654_3210);
    send_access(CMD_READ,  32'hFFFF_FFFC, 2'd3, 1'b0, 64'd0);
    send_access(CMD_READ,  32'hFFFF_FFFF, 2'd0, 1'b1, 64'd0);
    send_access(CMD_READ,  32'h0000_0000, 2'd1, 1'b1, 64'd0);
    send_access(CMD_READ,  32'hFFFF_FFFE, 2'd2, 1'b1, 64'd0);
    send_access(CMD_READ,  32'hFFFF_FFFC, 2'd3, 1'b1, 64'd0);
    send_access(CMD_WRITE, 32'h1234_5600, 2'd0, 1'b0, 64'd0);
    send_access(CMD_WRITE, 32'hFFFF_FFFC, 2'd3, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_WRITE, 32'hFFFF_FFFC, 2'd3, 1'b0, 64'd0);
    set_order(1'b1);
    send_access(CMD_WRITE, 32'h8000_00FE, 2'd2, 1'b0, 64'h0000_0000_8001_0203);
    send_access(CMD_READ,  32'h8000_00FE, 2'd2, 1'b1, 64'd0);
    send_access(CMD_READ,  32'h8000_00FE, 2'd1, 1'b1, 64'd0);
    set_order(1'b0);
    send_access(CMD_READ,  32'h8000_00FE, 2'd2, 1'b0, 64'd0);
    // Fill every slot, then write across a page boundary while the pool is full.
    for (int p = 0; p < PAGE_SLOTS; p++)
      send_access(CMD_WRITE, {8'h40, 8'(p), 16'h0080}, 2'd0, 1'b0, 64'h5A);
    send_access(CMD_WRITE, 32'h40FF_FFFE, 2'd2, 1'b0, 64'h0101_0101);
    send_access(CMD_READ,  32'h40FF_FFFE, 2'd2, 1'b0, 64'd0);
    for (int p = 0; p < PAGE_SLOTS; p++)
      send_access(CMD_WRITE, {8'h40, 8'(p), 16'h0080}, 2'd0, 1'b0, 64'h0);
    send_access(CMD_WRITE, 32'h40FF_FFFE, 2'd2, 1'b0, 64'h0);
    send_access(CMD_WRITE, 32'h4000_FFFE, 2'd2, 1'b0, 64'h0);

    // Random phases with varied idling and byte order.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 12 : 0;
      set_order(ph == 1);
      if (ph == 2) hold_cycles = 300;   // receiver stalls, input backs up
      for (int i = 0; i < 185; i++) random_access();
      if (ph == 0) drain();             // sender pauses until all results are back
    end
    recv_idle_pct = 0;
    drain();
    leftover = board.exp_data.size();
    $display("Ran %0d accesses in both byte orders; %0d hit a full page pool.",
             board.checked, board.full_hits);
    if (board.mismatches == 0 && leftover == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
